// ===== hdl/mlm_pkg.sv =====
// Shared constants and types for the line median block.
`timescale 1ns / 1ps

package mlm_pkg;

    localparam int MAX_LEN_DEF    = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int SAMPLE_W       = 32;

    typedef enum logic [1:0] {
        CMP_UNSIGNED = 2'd0,
        CMP_SIGNED   = 2'd1,
        CMP_FLOAT    = 2'd2,
        CMP_SPARE    = 2'd3
    } cmp_kind_t;

    // Control from the top level to the select engine.
    typedef struct packed {
        logic start;
        logic cmp_signed;
        logic cmp_float;
    } sel_ctrl_t;

endpackage

// ===== hdl/mlm_select.sv =====
// Wirth selection engine working on the sample memory by read, compare and swap.
`timescale 1ns / 1ps

module mlm_select #(
    parameter int MAX_LEN    = mlm_pkg::MAX_LEN_DEF,
    parameter int DATA_WIDTH = mlm_pkg::DATA_WIDTH_DEF,
    parameter int AW         = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mlm_pkg::sel_ctrl_t    ctrl,
    input  logic [AW:0]           count,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PIV   = 10'b0000000010,
        S_PIVW  = 10'b0000000100,
        S_RDI   = 10'b0000001000,
        S_CMPI  = 10'b0000010000,
        S_RDJ   = 10'b0000100000,
        S_CMPJ  = 10'b0001000000,
        S_SWAP  = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } sel_state_t;

    localparam logic [DATA_WIDTH-1:0] SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [AW+1:0] ONE_S = (AW+2)'(1);

    logic [DATA_WIDTH-1:0] mem [MAX_LEN];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    sel_state_t state_reg, state_next;
    logic signed [AW+1:0] l_reg, l_next, m_reg, m_next, i_reg, i_next, j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next, vi_reg, vi_next;
    logic cs_reg, cf_reg;
    logic done_reg, done_next;

    logic          mw_en;
    logic [AW-1:0] mw_addr;
    logic [DATA_WIDTH-1:0] mw_data;
    logic [AW-1:0] rd_addr;

    function automatic logic [DATA_WIDTH-1:0] okey(input logic [DATA_WIDTH-1:0] v,
                                                    input logic sg, input logic fl);
        logic [DATA_WIDTH-1:0] r;
        r = v;
        if (sg)
            r = v ^ SIGN;
        else if (fl)
        begin
            if ((v & ~SIGN) == '0)
                r = SIGN;
            else if (v[DATA_WIDTH-1])
                r = ~v;
            else
                r = v | SIGN;
        end
        return r;
    endfunction

    logic [DATA_WIDTH-1:0] key_rd, key_x;
    assign key_rd = okey(rd_data_reg, cs_reg, cf_reg);
    assign key_x  = okey(x_reg, cs_reg, cf_reg);

    always_ff @(posedge clk)
    begin
        if (mw_en)
            mem[mw_addr] <= mw_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        l_next = l_reg; m_next = m_reg; i_next = i_reg; j_next = j_reg;
        k_next = k_reg; x_next = x_reg; vi_next = vi_reg;
        done_next = 1'b0;
        mw_en = wr_en; mw_addr = wr_addr; mw_data = wr_data;
        rd_addr = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    k_next = AW'(count >> 1);
                    l_next = '0;
                    m_next = $signed({1'b0, count}) - ONE_S;
                    state_next = S_PIV;
                end
            end
            S_PIV:
            begin
                if (l_reg < m_reg)
                begin
                    rd_addr = k_reg;
                    state_next = S_PIVW;
                end
                else
                begin
                    rd_addr = k_reg;
                    state_next = S_FIN;
                end
            end
            S_PIVW:
            begin
                x_next = rd_data_reg;
                i_next = l_reg;
                j_next = m_reg;
                rd_addr = AW'(l_reg);
                state_next = S_CMPI;
            end
            S_RDI:
            begin
                rd_addr = AW'(i_reg);
                state_next = S_CMPI;
            end
            S_CMPI:
            begin
                // i never leaves the range here since x lies in the partition.
                if (key_rd < key_x)
                begin
                    i_next = i_reg + ONE_S;
                    state_next = S_RDI;
                end
                else
                begin
                    vi_next = rd_data_reg;
                    rd_addr = AW'(j_reg);
                    state_next = S_CMPJ;
                end
            end
            S_RDJ:
            begin
                rd_addr = AW'(j_reg);
                state_next = S_CMPJ;
            end
            S_CMPJ:
            begin
                if (key_rd > key_x)
                begin
                    j_next = j_reg - ONE_S;
                    state_next = S_RDJ;
                end
                else if (i_reg <= j_reg)
                begin
                    mw_en = 1'b1;
                    mw_addr = AW'(i_reg);
                    mw_data = rd_data_reg;
                    state_next = S_SWAP;
                end
                else
                    state_next = S_NEXT;
            end
            S_SWAP:
            begin
                mw_en = 1'b1;
                mw_addr = AW'(j_reg);
                mw_data = vi_reg;
                i_next = i_reg + ONE_S;
                j_next = j_reg - ONE_S;
                if (i_reg + ONE_S <= j_reg - ONE_S)
                    state_next = S_RDI;
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (j_reg < $signed({2'b0, k_reg}))
                    l_next = i_reg;
                if ($signed({2'b0, k_reg}) < i_reg)
                    m_next = j_reg;
                state_next = S_PIV;
            end
            S_FIN:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next; m_reg <= m_next; i_reg <= i_next; j_reg <= j_next;
        k_reg <= k_next; x_reg <= x_next; vi_reg <= vi_next;
        if (state_reg == S_IDLE && ctrl.start)
        begin
            cs_reg <= ctrl.cmp_signed;
            cf_reg <= ctrl.cmp_float;
        end
    end

    assign done   = done_reg;
    assign result = rd_data_reg;

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> done_reg) else $error("done missing after finish");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE)) else $error("done outside idle");
    a_swap_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP) |-> $past(state_reg == S_CMPJ)) else $error("bad swap entry");

endmodule

// ===== hdl/masked_line_median.sv =====
// Top level: line loading, overflow tracking and result register around the select engine.
//   channel | direction | fields
//   s_axis  | in        | tdata: sample; tuser: keep; tlast: last_of_line
//   m_axis  | out       | tdata: median_value, empty_line, overflowed
//   cfg     | in        | compare_kind
// A last beat with kept samples starts a selection.
// Each compare reads a sample and then compares it with the pivot, each swap writes both
// samples back, and each partition pass also reads the pivot and narrows the range.
// rst_n clears count, flags and control state; result fields and memory are not reset.
// Input stalls while a selection runs; a last beat also waits until the result is taken.
`timescale 1ns / 1ps

module masked_line_median #(
    parameter int MAX_LEN    = mlm_pkg::MAX_LEN_DEF,
    parameter int DATA_WIDTH = mlm_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample
    input  logic        s_axis_tuser,   // keep
    input  logic        s_axis_tlast,   // last_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // median_value, empty_line, overflowed, zero fill
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data     // compare_kind
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [1:0] kind_reg;
    logic [AW:0] count_reg;
    logic ovf_reg, busy_reg, ovf_out_reg;
    logic out_valid_reg;
    logic [31:0] med_reg;
    logic empty_reg;
    logic acc, store;
    logic done;
    logic [DATA_WIDTH-1:0] sel_result;
    mlm_pkg::sel_ctrl_t ctrl;
    logic start;

    // Sample beats keep loading while a result waits; only a last beat needs the register.
    assign s_axis_tready = !busy_reg && !(out_valid_reg && s_axis_tlast);
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign store = acc && s_axis_tuser && (count_reg < (AW+1)'(MAX_LEN));

    logic [AW:0] cnt_fin;
    assign cnt_fin = count_reg + (AW+1)'(store);
    assign start   = acc && s_axis_tlast && (cnt_fin != '0);

    assign ctrl.start      = start;
    assign ctrl.cmp_signed = (kind_reg == mlm_pkg::CMP_SIGNED);
    assign ctrl.cmp_float  = (kind_reg == mlm_pkg::CMP_FLOAT);

    logic [DATA_WIDTH-1:0] din;
    assign din = DATA_WIDTH'(s_axis_tdata);

    mlm_select #(.MAX_LEN(MAX_LEN), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_sel (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .count(cnt_fin),
        .wr_en(store), .wr_addr(count_reg[AW-1:0]), .wr_data(din),
        .done(done), .result(sel_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= mlm_pkg::CMP_UNSIGNED;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                kind_reg <= cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (done)
            begin
                busy_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            if (acc)
            begin
                if (s_axis_tlast)
                begin
                    count_reg <= '0;
                    ovf_reg <= 1'b0;
                    if (start)
                        busy_reg <= 1'b1;
                    else
                        out_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= cnt_fin;
                    if (s_axis_tuser && !store)
                        ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && s_axis_tlast)
        begin
            ovf_out_reg <= ovf_reg || (s_axis_tuser && !store);
            empty_reg <= !start;
            med_reg <= '0;
        end
        if (done)
            med_reg <= 32'(sel_result);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, ovf_out_reg, empty_reg, med_reg};

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !out_valid_reg) else $error("result shown while selecting");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(MAX_LEN)) else $error("count beyond depth");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done without selection");

endmodule

// ===== test/masked_line_median_tb.sv =====
// Self-checking testbench for the masked line median block: random lines, three orders.
`timescale 1ns / 1ps

module masked_line_median_tb;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] sample;
        logic        keep;
        logic        last;
    } beat_t;

    typedef struct packed {
        logic [31:0] median;
        logic        empty;
        logic        ovf;
    } median_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;

    masked_line_median u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    beat_t     pending_beats[$];
    median_t   expected_medians[$];
    mlm_pkg::cmp_kind_t order_kind;
    logic [31:0] line_buf[DEPTH];
    int        line_count;
    logic      line_ovf;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;
    int  errors;
    int  stall_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Key whose unsigned order matches the selected sample order.
    function automatic logic [31:0] order_key(input logic [31:0] v);
        if (order_kind == mlm_pkg::CMP_SIGNED)
            return v ^ 32'h8000_0000;
        if (order_kind == mlm_pkg::CMP_FLOAT)
        begin
            if (v[30:0] == 31'd0)
                return 32'h8000_0000;
            if (v[31])
                return ~v;
            return v | 32'h8000_0000;
        end
        return v;
    endfunction

    // Wirth selection of element k among the first n buffered samples.
    function automatic logic [31:0] wirth_select(input int n, input int k);
        int lo;
        int hi;
        int i;
        int j;
        logic [31:0] pivot;
        logic [31:0] t;
        lo = 0;
        hi = n - 1;
        while (lo < hi)
        begin
            pivot = order_key(line_buf[k]);
            i = lo;
            j = hi;
            do
            begin
                while (i < n && order_key(line_buf[i]) < pivot) i++;
                while (j >= 0 && order_key(line_buf[j]) > pivot) j--;
                if (i <= j && i < n && j >= 0)
                begin
                    t = line_buf[i];
                    line_buf[i] = line_buf[j];
                    line_buf[j] = t;
                    i++;
                    j--;
                end
            end while (i <= j);
            if (j < k) lo = i;
            if (k < i) hi = j;
        end
        return line_buf[k];
    endfunction

    task automatic predict_beat(input beat_t b);
        median_t r;
        if (b.keep)
        begin
            if (line_count < DEPTH)
            begin
                line_buf[line_count] = b.sample;
                line_count++;
            end
            else
                line_ovf = 1'b1;
        end
        if (b.last)
        begin
            if (line_count == 0)
            begin
                r.median = '0;
                r.empty = 1'b1;
            end
            else
            begin
                r.median = wirth_select(line_count, line_count / 2);
                r.empty = 1'b0;
            end
            r.ovf = line_ovf;
            expected_medians.push_back(r);
            line_count = 0;
            line_ovf = 1'b0;
        end
    endtask

    function automatic logic [31:0] rand_sample(input int flavor);
        logic [31:0] v;
        v = $urandom;
        case (flavor)
            0: v = $urandom_range(0, 15);
            1: v = {v[31], 8'hFF, v[22:0]};
            2: v = {v[31], 31'd0};
            3: v = {v[31], 31'd0} | $urandom_range(0, 3);
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_line(input int len, input int keep_pct, input int flavor);
        beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.sample = rand_sample(flavor);
            b.keep = ($urandom_range(0, 99) < keep_pct);
            b.last = (i == len - 1);
            pending_beats.push_back(b);
        end
    endtask

    task automatic queue_beat(input logic [31:0] s, input logic k, input logic l);
        beat_t b;
        b.sample = s;
        b.keep = k;
        b.last = l;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_medians.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        // A final non-last beat may still be loading.
        repeat (20) @(posedge clk);
    endtask

    task automatic write_order(input mlm_pkg::cmp_kind_t k);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= k;
        order_kind = k;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int queued;
        int len;
        queued = 0;
        while (queued < n_items)
        begin
            if ($urandom_range(0, 49) == 0)
                len = $urandom_range(250, 300);
            else
                len = $urandom_range(1, 12);
            queue_line(len, $urandom_range(0, 3) == 0 ? 30 : 85, $urandom_range(0, 5));
            queued += len;
        end
    endtask

    // Driver: offers queued beats, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_beat({s_axis_tdata, s_axis_tuser, s_axis_tlast});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    beat_t b;
                    b = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= b.sample;
                    s_axis_tuser <= b.keep;
                    s_axis_tlast <= b.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    median_t e;
                    e = expected_medians.pop_front();
                    if (m_axis_tdata[31:0] !== e.median)
                    begin
                        $display("%0t: median expected %h actual %h", $realtime,
                                 e.median, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[32] !== e.empty)
                    begin
                        $display("%0t: empty expected %b actual %b", $realtime,
                                 e.empty, m_axis_tdata[32]);
                        errors++;
                    end
                    if (m_axis_tdata[33] !== e.ovf)
                    begin
                        $display("%0t: overflow expected %b actual %b", $realtime,
                                 e.ovf, m_axis_tdata[33]);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || hold_off_cycles > 0)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = mlm_pkg::CMP_UNSIGNED;
        order_kind = mlm_pkg::CMP_UNSIGNED;
        line_count = 0;
        line_ovf = 1'b0;
        errors = 0;
        stall_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 85;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty line, extremes, even/odd counts, skipped samples.
        queue_beat(32'h0, 1'b0, 1'b1);
        queue_beat(32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_beat(32'h0, 1'b1, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_beat(32'h0000_0001, 1'b1, 1'b1);
        queue_beat(32'h1234_5678, 1'b1, 1'b0);
        queue_beat(32'h5555_AAAA, 1'b0, 1'b1);
        wait_drained();

        write_order(mlm_pkg::CMP_SIGNED);
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b1, 1'b1);
        random_phase(200);
        wait_drained();

        write_order(mlm_pkg::CMP_FLOAT);
        // Zeros of both signs, infinities and NaNs of both signs.
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h0000_0000, 1'b1, 1'b0);
        queue_beat(32'hFF80_0000, 1'b1, 1'b0);
        queue_beat(32'hFFC0_0001, 1'b1, 1'b0);
        queue_beat(32'h7F80_0000, 1'b1, 1'b0);
        queue_beat(32'h7FC0_0000, 1'b1, 1'b1);
        random_phase(200);
        wait_drained();

        // Buffer overflow with the last beat kept and dropped.
        write_order(mlm_pkg::CMP_SPARE);
        queue_line(DEPTH + 3, 100, 5);
        queue_line(DEPTH, 100, 0);
        queue_beat(32'hDEAD_BEEF, 1'b1, 1'b1);
        // Long receiver hold-off so the block stalls its input.
        hold_off_cycles <= 3000;
        random_phase(200);
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 9;
        write_order(mlm_pkg::CMP_UNSIGNED);
        random_phase(350);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_order(mlm_pkg::CMP_FLOAT);
        random_phase(250);
        wait_drained();
        write_order(mlm_pkg::CMP_SIGNED);
        random_phase(150);
        wait_drained();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mlm_pkg.sv
hdl/mlm_select.sv
hdl/masked_line_median.sv
test/masked_line_median_tb.sv
